[design/ramped_gain_two_sources_assert.svh]
// Assertion macros for the ramped gain block.
`ifndef RAMPED_GAIN_TWO_SOURCES_ASSERT_SVH
`define RAMPED_GAIN_TWO_SOURCES_ASSERT_SVH
`define RG_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RG_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[design/rg_pkg.sv]
// Shared types and constants for the ramped gain block.
package rg_pkg;
    localparam int ACC_FRAC = 32;
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_KNOB   = 2'd1,
        ACT_POINT  = 2'd2,
        ACT_BLOCK  = 2'd3
    } t_action;
endpackage

[design/rg_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rg_div #(
    parameter int NW = 34,
    parameter int DW = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic        [DW-1:0] i_den,
    output logic                 o_busy,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW+1:0] w_trial;
    logic [DW+1:0] w_sh;

    assign w_sh    = {r_rem, r_q[NW-1]};
    assign w_trial = w_sh - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_neg  <= i_num[NW-1];
                r_q    <= i_num[NW-1] ? (~i_num + 1'b1) : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_trial[DW+1]) begin
                    r_rem <= w_trial[DW:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[DW:0];
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(~r_q + 1'b1) : $signed(r_q);
endmodule

[design/rg_front.sv]
// Input stage: accepts requests and holds them in a short queue.
module rg_front #(
    parameter int IW = 58,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [IW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [IW-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);
    logic [IW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

[design/ramped_gain_two_sources.sv]
// Ramped gain: a front queue feeds a back end that runs the ramps and a two-stage multiply.
// A sample passes the front queue, the multiply stage and the output register in turn.
// Samples flow one per cycle unless the output stalls or a division runs. A block start
// after a knob target and an accepted control point each start such a division.
// Reset (synchronous, active low) restores unity knob, zero control, length 512.
module ramped_gain_two_sources
    import rg_pkg::*;
#(
    parameter int MAX_BLOCK = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [12:0] i_cfg_wdata,
    input  logic i_cfg_we,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // sample_in, target_level, point_offset (lowest bit first), zero fill
    input  logic [((SAMPLE_BITS+LEVEL_FRAC_BITS+13+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    // action, block_has_control (lowest bit first)
    input  logic [2:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // sample_out, gain_now (lowest bit first), zero fill
    output logic [((SAMPLE_BITS+LEVEL_FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    localparam int F = LEVEL_FRAC_BITS;
    localparam int LW = F + 1;
    localparam int SH = ACC_FRAC - F;
    localparam int PW = $clog2(MAX_BLOCK + 1);
    localparam int AW = ACC_FRAC + 2;
    localparam int IW = SAMPLE_BITS + LW + 12 + 1 + 3;
    localparam int OB = ((SAMPLE_BITS + LW + 7) / 8) * 8;
    localparam logic signed [AW-1:0] ACC_ONE = AW'(64'd1 << ACC_FRAC);
    localparam logic [LW-1:0] LONE = LW'(1) << F;

    `include "ramped_gain_two_sources_assert.svh"

    logic [12:0] r_len_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len_cfg <= 13'd512;
        else if (i_cfg_we) r_len_cfg <= i_cfg_wdata;
    end
    logic [PW-1:0] w_len;
    always_comb begin
        if (r_len_cfg == '0) w_len = PW'(1);
        else if (32'(r_len_cfg) > MAX_BLOCK) w_len = PW'(MAX_BLOCK);
        else w_len = PW'(r_len_cfg);
    end

    logic [IW-1:0] w_in, w_q;
    logic w_qv, w_qr;
    assign w_in = {s_axis_tuser, s_axis_tlast,
                   s_axis_tdata[SAMPLE_BITS+LW+12-1:0]};
    rg_front #(.IW(IW), .DEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_q));

    logic signed [SAMPLE_BITS-1:0] q_smp;
    logic [LW-1:0] q_tgt_raw, q_tgt;
    logic [11:0] q_off;
    logic q_fe, q_bhc;
    t_action q_act;
    assign q_smp = w_q[SAMPLE_BITS-1:0];
    assign q_tgt_raw = w_q[SAMPLE_BITS +: LW];
    assign q_off = w_q[SAMPLE_BITS+LW +: 12];
    assign q_fe = w_q[SAMPLE_BITS+LW+12];
    assign q_act = t_action'(w_q[SAMPLE_BITS+LW+13 +: 2]);
    assign q_bhc = w_q[SAMPLE_BITS+LW+15];
    assign q_tgt = (q_tgt_raw > LONE) ? LONE : q_tgt_raw;

    logic signed [AW-1:0] r_knob, r_kstep, r_ctl, r_cstep;
    logic [LW-1:0] r_kpend;
    logic r_kchg, r_cen;
    logic [PW-1:0] r_pos, r_segend;

    logic signed [AW-1:0] w_knext, w_cnext;
    assign w_knext = r_knob + r_kstep;
    assign w_cnext = r_ctl + r_cstep;

    logic r_div_kind;
    logic [PW-1:0] r_div_seg;
    logic w_dstart, w_dbusy, w_ddone;
    logic signed [AW-1:0] w_dnum, w_dq;
    logic [PW-1:0] w_dden;
    rg_div #(.NW(AW), .DW(PW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_busy(w_dbusy), .o_done(w_ddone),
        .o_quot(w_dq));

    logic w_opfree, w_pt_ok, w_is_smp;
    logic [LW-1:0] w_k, w_c;
    logic [2*LW-1:0] w_cm;
    logic [LW:0] w_gsum;
    logic [LW-1:0] w_gain;
    assign w_pt_ok = r_cen && ({1'b0, q_off} < 13'(w_len)) && (PW'(q_off) > r_pos);
    assign w_k = LW'(r_knob >>> SH);
    assign w_c = LW'(r_ctl >>> SH);
    assign w_cm = w_c * (LONE - w_k);
    assign w_gsum = {1'b0, w_k} + (LW+1)'(w_cm >> F);
    assign w_gain = (w_gsum > (LW+1)'(LONE)) ? LONE : LW'(w_gsum);

    logic r_p1v;
    logic [SAMPLE_BITS-1:0] r_p1mag;
    logic r_p1neg, r_p1fe;
    logic [LW-1:0] r_p1g;
    logic [SAMPLE_BITS+LW-1:0] w_prod;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic r_ov;
    logic [SAMPLE_BITS-1:0] r_osmp;
    logic [LW-1:0] r_og;
    logic r_ofe;
    assign w_prod = r_p1mag * r_p1g;
    assign w_mag = SAMPLE_BITS'(w_prod >> F);

    assign w_opfree = !r_ov || m_axis_tready;
    assign w_is_smp = (q_act == ACT_SAMPLE);
    assign w_qr = !w_dbusy && !w_ddone && (!w_is_smp || w_opfree);

    always_comb begin
        w_dstart = 1'b0;
        w_dnum = '0;
        w_dden = PW'(1);
        if (w_qv && w_qr) begin
            case (q_act)
                ACT_POINT: begin
                    w_dstart = w_pt_ok;
                    w_dnum = (AW'(q_tgt) <<< SH) - r_ctl;
                    w_dden = PW'(q_off) - r_pos;
                end
                ACT_BLOCK: begin
                    w_dstart = r_kchg;
                    w_dnum = (AW'(r_kpend) <<< SH) - r_knob;
                    w_dden = w_len;
                end
                default: w_dstart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob <= ACC_ONE; r_kstep <= '0; r_kpend <= LONE; r_kchg <= 1'b0;
            r_ctl <= '0; r_cstep <= '0; r_cen <= 1'b0;
            r_pos <= '0; r_segend <= '0; r_div_kind <= 1'b0; r_div_seg <= '0;
            r_p1v <= 1'b0;
        end else begin
            if (w_opfree) r_p1v <= w_qv && w_qr && w_is_smp;
            if (w_ddone) begin
                if (r_div_kind) r_kstep <= w_dq;
                else begin
                    r_cstep <= w_dq;
                    r_segend <= r_div_seg;
                end
            end
            if (w_qv && w_qr) begin
                case (q_act)
                    ACT_KNOB: begin
                        r_kpend <= q_tgt;
                        r_kchg <= 1'b1;
                    end
                    ACT_POINT: begin
                        r_div_kind <= 1'b0;
                        r_div_seg <= PW'(q_off);
                    end
                    ACT_BLOCK: begin
                        r_pos <= '0; r_segend <= '0; r_cstep <= '0;
                        r_cen <= q_bhc;
                        r_div_kind <= 1'b1;
                        if (r_kchg) r_kchg <= 1'b0;
                        else begin
                            r_knob <= AW'(r_kpend) <<< SH;
                            r_kstep <= '0;
                        end
                        if (!q_bhc) r_ctl <= '0;
                    end
                    default: begin
                        r_p1neg <= q_smp[SAMPLE_BITS-1];
                        r_p1mag <= q_smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-q_smp)
                                                        : SAMPLE_BITS'(q_smp);
                        r_p1g <= w_gain;
                        r_p1fe <= q_fe;
                        if (q_fe) begin
                            if (r_pos < w_len) begin
                                if (w_knext < 0) r_knob <= '0;
                                else if (w_knext > ACC_ONE) r_knob <= ACC_ONE;
                                else r_knob <= w_knext;
                            end
                            if (r_pos < r_segend) begin
                                if (w_cnext < 0) r_ctl <= '0;
                                else if (w_cnext > ACC_ONE) r_ctl <= ACC_ONE;
                                else r_ctl <= w_cnext;
                            end
                            if (r_pos < PW'(MAX_BLOCK)) r_pos <= r_pos + 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // The sample stage only fills when the output register can take it next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_opfree) begin
            r_ov <= r_p1v;
            r_osmp <= r_p1neg ? (~w_mag + 1'b1) : w_mag;
            r_og <= r_p1g;
            r_ofe <= r_p1fe;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast = r_ofe;
    assign m_axis_tdata = OB'({r_og, r_osmp});

    `RG_ASSERT_IMPL(a_gain_max, i_clk, i_rst_n, r_ov, r_og <= LONE)
    `RG_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !m_axis_tready,
                    r_ov && $stable(r_osmp))
    `RG_ASSERT_IMPL(a_div_stall, i_clk, i_rst_n, w_dbusy, !w_qr)
endmodule

[tb/testbench.sv]
// Self-checking testbench for the ramped gain block with knob and control ramps.
`timescale 1ns / 100ps

module testbench;
    import rg_pkg::*;

    localparam int MAXB = 4096;
    localparam int SB = 24;
    localparam int FB = 16;
    localparam int DW = ((SB + FB + 13 + 7) / 8) * 8;
    localparam int OW = ((SB + FB + 1 + 7) / 8) * 8;
    localparam longint ACC_ONE = 64'sd1 << 32;
    localparam longint LVL_ONE = 64'sd1 << FB;
    localparam int SETTLE = 80;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [SB-1:0] smp;
        logic          last;
        logic [FB:0]   gain;
    } t_result;

    typedef struct {
        t_action     act;
        logic [SB-1:0] smp;
        logic        fe;
        logic [FB:0] lvl;
        logic [11:0] off;
        logic        hc;
        logic        chk;
        t_result     exp_res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic [12:0] cfg_wdata;
    logic cfg_we;
    logic s_tvalid, s_tready, s_tlast;
    logic [DW-1:0] s_tdata;
    logic [2:0] s_tuser;
    logic m_tvalid, m_tready, m_tlast;
    logic [OW-1:0] m_tdata;

    ramped_gain_two_sources u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wdata(cfg_wdata), .i_cfg_we(cfg_we),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tlast(s_tlast), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tlast(m_tlast)
    );

    // Predictor state of the gain path.
    int unsigned blk_len;
    longint knob_acc, knob_inc, ctl_acc, ctl_inc;
    longint knob_pending;
    bit knob_new, ctl_on;
    int unsigned pos, seg_end;

    t_result scaled_q[$];
    int errors = 0;
    int n_checked = 0;
    longint cycles = 0;
    bit quiet_rx = 0;
    bit quiet_tx = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint clamp_lvl(logic [FB:0] t);
        return (t > LVL_ONE) ? LVL_ONE : longint'(t);
    endfunction

    function automatic longint clamp_ramp(longint a);
        if (a < 0) return 0;
        if (a > ACC_ONE) return ACC_ONE;
        return a;
    endfunction

    function automatic int unsigned len_in_use();
        if (blk_len == 0) return 1;
        if (blk_len > MAXB) return MAXB;
        return blk_len;
    endfunction

    function automatic void gain_reset();
        blk_len = 512;
        knob_acc = ACC_ONE;
        knob_inc = 0;
        knob_pending = LVL_ONE;
        knob_new = 0;
        ctl_acc = 0;
        ctl_inc = 0;
        ctl_on = 0;
        pos = 0;
        seg_end = 0;
    endfunction

    // Applies one request to the predictor; returns 1 when it makes a result.
    function automatic bit predict_gain(t_action act, logic [SB-1:0] smp, logic fe,
                                        logic [FB:0] lvl, logic [11:0] off, logic hc,
                                        output t_result r);
        int unsigned len;
        longint k, c, g, mag, res;
        bit neg;
        len = len_in_use();
        r = '0;
        case (act)
            ACT_KNOB: begin
                knob_pending = clamp_lvl(lvl);
                knob_new = 1;
                return 0;
            end
            ACT_POINT: begin
                if (ctl_on && off < len && off > pos) begin
                    ctl_inc = ((clamp_lvl(lvl) <<< 16) - ctl_acc) / longint'(off - pos);
                    seg_end = off;
                end
                return 0;
            end
            ACT_BLOCK: begin
                pos = 0;
                seg_end = 0;
                ctl_inc = 0;
                ctl_on = hc;
                if (knob_new) begin
                    knob_inc = ((knob_pending <<< 16) - knob_acc) / longint'(len);
                    knob_new = 0;
                end else begin
                    knob_acc = knob_pending <<< 16;
                    knob_inc = 0;
                end
                if (!ctl_on) ctl_acc = 0;
                return 0;
            end
            default: begin
                k = knob_acc >>> 16;
                c = ctl_acc >>> 16;
                g = k + ((c * (LVL_ONE - k)) >>> FB);
                if (g > LVL_ONE) g = LVL_ONE;
                neg = smp[SB-1];
                mag = neg ? (longint'(1) << SB) - longint'(smp) : longint'(smp);
                mag = (mag * g) >>> FB;
                res = neg ? -mag : mag;
                r.smp = res[SB-1:0];
                r.last = fe;
                r.gain = g[FB:0];
                if (fe) begin
                    if (pos < len) knob_acc = clamp_ramp(knob_acc + knob_inc);
                    if (pos < seg_end) ctl_acc = clamp_ramp(ctl_acc + ctl_inc);
                    if (pos < MAXB) pos++;
                end
                return 1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.smp = m_tdata[SB-1:0];
            got.gain = m_tdata[SB+FB:SB];
            got.last = m_tlast;
            if (scaled_q.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = scaled_q.pop_front();
                n_checked++;
                if (got.smp !== want.smp) begin
                    $error("sample_out expected %h got %h", want.smp, got.smp);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("frame_done expected %b got %b", want.last, got.last);
                    errors++;
                end
                if (got.gain !== want.gain) begin
                    $error("gain_now expected %h got %h", want.gain, got.gain);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 0;
        else m_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 9);
    end

    task automatic send(t_action act, logic [SB-1:0] smp, logic fe, logic [FB:0] lvl,
                        logic [11:0] off, logic hc);
        t_result r;
        if (predict_gain(act, smp, fe, lvl, off, hc, r)) scaled_q.push_back(r);
        while (!quiet_tx && $urandom_range(99) < 9) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata <= DW'({off, lvl, smp});
        s_tlast <= fe;
        s_tuser <= {hc, act};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 0;
        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(logic [12:0] v);
        drain_and_idle();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 0;
        blk_len = v;
    endtask

    // One block: an optional knob target, a start, optional control points and frames of two channels.
    task automatic random_block(int unsigned frames);
        logic [FB:0] lv;
        if ($urandom_range(3) == 0) begin
            lv = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
            send(ACT_KNOB, 24'($urandom), 1'b0, lv, 12'($urandom), 1'($urandom));
        end
        send(ACT_BLOCK, 24'($urandom), 1'($urandom), 17'($urandom), 12'($urandom),
             $urandom_range(3) != 0);
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(5) == 0) begin
                lv = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
                send(ACT_POINT, 24'($urandom), 1'b0, lv,
                     ($urandom_range(5) == 0) ? 12'($urandom)
                         : 12'(pos + 1 + $urandom_range(frames)), 1'($urandom));
            end
            send(ACT_SAMPLE, 24'($urandom), 1'b0, 17'($urandom), 12'($urandom),
                 1'($urandom));
            send(ACT_SAMPLE, 24'($urandom), 1'b1, 17'($urandom), 12'($urandom),
                 1'($urandom));
        end
    endtask

    initial begin
        t_row rows[$];
        t_row rw;
        int sent;
        logic [12:0] lens[6] = '{13'd1, 13'd8, 13'd0, 13'd8191, 13'd4096, 13'd20};

        gain_reset();
        i_rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        s_tuser = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed rows: unity gain after reset, then knob and control ramps.
        rows = '{
            '{ACT_SAMPLE, 24'h7FFFFF, 1'b0, 17'd0, 12'd0, 1'b0, 1'b1,
              t_result'{24'h7FFFFF, 1'b0, 17'h10000}},
            '{ACT_SAMPLE, 24'h800000, 1'b1, 17'd0, 12'd0, 1'b0, 1'b1,
              t_result'{24'h800000, 1'b1, 17'h10000}},
            '{ACT_KNOB, 24'd0, 1'b0, 17'h1FFFF, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_KNOB, 24'd0, 1'b0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_BLOCK, 24'd0, 1'b0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'h123456, 1'b1, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'hFFFFFF, 1'b1, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_BLOCK, 24'd0, 1'b0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'h7FFFFF, 1'b1, 17'd0, 12'd0, 1'b0, 1'b1,
              t_result'{24'h000000, 1'b1, 17'h00000}},
            '{ACT_POINT, 24'd0, 1'b0, 17'h10000, 12'd9, 1'b0, 1'b0, '0},
            '{ACT_BLOCK, 24'd0, 1'b0, 17'd0, 12'd0, 1'b1, 1'b0, '0},
            '{ACT_POINT, 24'd0, 1'b0, 17'h10000, 12'd4095, 1'b0, 1'b0, '0},
            '{ACT_POINT, 24'd0, 1'b0, 17'h10000, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_POINT, 24'd0, 1'b0, 17'h1FFFF, 12'd3, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'h400000, 1'b1, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'hC00000, 1'b1, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_POINT, 24'd0, 1'b0, 17'd100, 12'd1, 1'b0, 1'b0, '0},
            '{ACT_POINT, 24'd0, 1'b0, 17'd0, 12'd6, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'h7FFFFF, 1'b0, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'h800000, 1'b1, 17'd0, 12'd0, 1'b0, 1'b0, '0},
            '{ACT_SAMPLE, 24'h000001, 1'b1, 17'd0, 12'd0, 1'b0, 1'b0, '0}
        };
        foreach (rows[i]) begin
            rw = rows[i];
            send(rw.act, rw.smp, rw.fe, rw.lvl, rw.off, rw.hc);
            if (rw.chk && scaled_q[$] !== rw.exp_res) begin
                $error("directed row %0d: predictor expected %h got %h",
                       i, rw.exp_res, scaled_q[$]);
                errors++;
            end
        end

        sent = 0;
        foreach (lens[i]) begin
            write_length(lens[i]);
            quiet_tx = (i == 2);
            quiet_rx = (i == 2);
            for (int b = 0; b < 6; b++) begin
                int unsigned fr;
                fr = (len_in_use() > 64 && $urandom_range(4) != 0)
                     ? $urandom_range(40) : len_in_use() + $urandom_range(3);
                if (fr > 64) fr = 64;
                random_block(fr);
                sent += 2 * fr;
            end
            while (sent < 250 * (i + 1)) begin
                random_block($urandom_range(30));
                sent += 30;
            end
        end
        quiet_tx = 0;
        quiet_rx = 0;
        drain_and_idle();

        $display("Covered %0d checked samples over six block lengths, with knob ramps,",
                 n_checked);
        $display("control point segments, ignored points and unity-clamped targets.");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[ramped_gain_two_sources.f]
+incdir+design
design/rg_pkg.sv
design/rg_div.sv
design/rg_front.sv
design/ramped_gain_two_sources.sv
tb/testbench.sv
